// ===== hdl/tfdt_pkg.sv =====
// ============================================================================
// tfdt_pkg
// Shared types and constants for the triangle fragment depth-test block.
// ============================================================================
package tfdt_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int FRAC_BITS  = 16;
    localparam int DIM_W      = 7;
    localparam int PIX_W      = 6;
    localparam int DB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int DB_AW      = $clog2(DB_DEPTH);
    localparam int SCR_W      = 30;
    localparam int PROD_W     = 62;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int DACC_W     = 50;

    localparam int DIV_RW = 63;
    localparam int DIV_NW = 48;
    localparam int DIV_CW = 6;

    localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] DEPTH_MIN = 32'h8000_0000;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_SKIP = 2'd1;
    localparam logic [1:0] KIND_TEST = 2'd2;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic               func;
        logic [1:0]         vertex_slot;
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
    } in_t;

    typedef struct packed {
        logic               written;
        logic               inside_res;
        logic               degenerate;
        logic [11:0]        pixel_index;
        logic signed [31:0] frag_depth;
        logic [WT_W-1:0]    alpha;
        logic [WT_W-1:0]    beta;
        logic [WT_W-1:0]    gamma;
    } out_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               wzero;
        logic [1:0]         slot;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] wd;
        logic [DIM_W-1:0] ht;
    } dims_t;

    typedef struct packed {
        logic              start;
        logic [DIV_RW-1:0] rem0;
        logic [DIV_RW-1:0] den;
        logic [DIV_NW-1:0] num;
        logic [DIV_CW-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_stat_t;

endpackage

// ===== hdl/triangle_fragment_depth_test.sv =====
// ============================================================================
// triangle_fragment_depth_test
// Triangle coverage and z-buffer depth test in s15.16 fixed point.
// ============================================================================
// Input transactions carry either a vertex load (func 0) or a pixel test
// (func 1) on in_valid/in_stall/in_data; every transaction yields exactly one
// result transaction on out_valid/out_stall/out_data, in order.
// A two-entry queue sits behind the input, and a result register sits at the
// output, so new transactions are taken while a result waits on a stall.
// Items are processed one at a time. A vertex load with nonzero w runs three
// 48-step divides in the one-bit-per-cycle divider. A covered pixel runs the
// edge functions on the shared multiplier, three 16-step weight divides, the
// depth sum and a read-modify-write of the depth buffer. Degenerate or
// uncovered pixels skip the weight divides and the depth buffer access.
// After reset the depth buffer is cleared to maximum depth, one entry a cycle;
// in_stall stays high during that pass, while configuration writes are taken
// as usual. A receiver stall holds the result register and, once the queue
// fills, backs up to in_stall.
// ============================================================================
module triangle_fragment_depth_test import tfdt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    dims_t            dims;
    logic             clearing;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // Zero acts as one, and sizes past the buffer are limited to it.
    always_comb
    begin
        if (width_reg == '0)
        begin
            dims.wd = DIM_W'(1);
        end
        else if (width_reg > DIM_W'(MAX_WIDTH))
        begin
            dims.wd = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            dims.wd = width_reg;
        end
        if (height_reg == '0)
        begin
            dims.ht = DIM_W'(1);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            dims.ht = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            dims.ht = height_reg;
        end
    end

    tfdt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data (in_data),
        .hold    (clearing),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    tfdt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .dims     (dims),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .clearing (clearing),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("input taken during depth buffer clear");

    a_written_needs_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.written |-> out_data.inside_res && !out_data.degenerate)
        else $error("depth write reported for uncovered or degenerate fragment");

    a_degen_no_weights: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.alpha == '0 && out_data.beta == '0 && out_data.gamma == '0)
        else $error("weights reported for degenerate triangle");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.inside_res |->
            ({2'b00, out_data.alpha} + {2'b00, out_data.beta} + {2'b00, out_data.gamma})
                <= 19'd65536)
        else $error("barycentric weights sum above one");
`endif

endmodule

// ===== hdl/tfdt_front.sv =====
// ============================================================================
// tfdt_front
// Input side: accepts transactions, classifies them and queues them.
// ============================================================================
module tfdt_front import tfdt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    input  logic hold,
    output logic q_valid,
    input  logic q_pop,
    output cmd_t q_item
);

    cmd_t       fifo_mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.slot  = in_data.vertex_slot;
        cmd_in.cx    = in_data.clip_x;
        cmd_in.cy    = in_data.clip_y;
        cmd_in.cz    = in_data.clip_z;
        cmd_in.cw    = in_data.clip_w;
        cmd_in.px    = in_data.pixel_x;
        cmd_in.py    = in_data.pixel_y;
        cmd_in.wzero = (in_data.clip_w == 32'sd0);
        if (in_data.func == FUNC_TEST)
        begin
            cmd_in.kind = KIND_TEST;
        end
        else if (in_data.vertex_slot == 2'd3)
        begin
            cmd_in.kind = KIND_SKIP;
        end
        else
        begin
            cmd_in.kind = KIND_LOAD;
        end
    end

    assign in_stall = hold || (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/tfdt_div.sv =====
// ============================================================================
// tfdt_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module tfdt_div import tfdt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);

    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_RW-1:0] den_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] quot_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   diff;
    logic              ge;

    // The remainder stays below the divisor, so one shifted-in bit always fits.
    assign trial = {rem_reg, num_reg[DIV_NW-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem0;
            den_reg  <= req.den;
            num_reg  <= req.num;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
            num_reg  <= {num_reg[DIV_NW-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_NW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= req.count;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/tfdt_back.sv =====
// ============================================================================
// tfdt_back
// Execution side: vertex setup, edge functions, weights, depth buffer test.
// ============================================================================
module tfdt_back import tfdt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  dims_t dims,
    input  logic  q_valid,
    output logic  q_pop,
    input  cmd_t  q_item,
    output logic  clearing,
    output logic  out_valid,
    input  logic  out_stall,
    output out_t  out_data
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LSTART = 5'd2;
    localparam logic [4:0] S_LWAIT  = 5'd3;
    localparam logic [4:0] S_MX     = 5'd4;
    localparam logic [4:0] S_MY     = 5'd5;
    localparam logic [4:0] S_MW     = 5'd6;
    localparam logic [4:0] S_XMUL   = 5'd7;
    localparam logic [4:0] S_XACC   = 5'd8;
    localparam logic [4:0] S_TCHK   = 5'd9;
    localparam logic [4:0] S_WSTART = 5'd10;
    localparam logic [4:0] S_WWAIT  = 5'd11;
    localparam logic [4:0] S_DMUL   = 5'd12;
    localparam logic [4:0] S_DACC   = 5'd13;
    localparam logic [4:0] S_DFIN   = 5'd14;
    localparam logic [4:0] S_RD     = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    localparam logic signed [40:0] MAP_HI = 41'sd536870911;
    localparam logic signed [40:0] MAP_LO = -41'sd536870912;
    localparam logic signed [DACC_W-1:0] DZ_HI = 50'sd2147483647;
    localparam logic signed [DACC_W-1:0] DZ_LO = -50'sd2147483648;

    logic [4:0]               state_reg;
    logic [4:0]               state_next;
    cmd_t                     cmd_reg;
    logic [2:0]               step_reg;
    logic signed [SCR_W-1:0]  sx_reg [0:2];
    logic signed [SCR_W-1:0]  sy_reg [0:2];
    logic signed [31:0]       sz_reg [0:2];
    logic [2:0]               wz_reg;
    logic signed [31:0]       qx_reg;
    logic signed [31:0]       qy_reg;
    logic signed [31:0]       qz_reg;
    logic signed [SCR_W-1:0]  mapx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] cross_reg [0:3];
    logic [WT_W-1:0]          wt_reg [0:2];
    logic signed [DACC_W-1:0] dacc_reg;
    logic signed [31:0]       depth_reg;
    logic [DB_AW-1:0]         idx_reg;
    logic                     in_range_reg;
    logic                     neg_reg;
    logic                     top_reg;
    out_t                     res_reg;
    logic                     out_valid_reg;
    out_t                     out_data_reg;
    logic [DB_AW-1:0]         clr_cnt_reg;
    logic [31:0]              rd_data_reg;
    logic [31:0]              depth_mem [0:DB_DEPTH-1];

    div_req_t                 div_req;
    div_stat_t                div_stat;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_p;
    logic signed [SCR_W-1:0]  ax, ay, bx, by, cx, cy, fx, fy;
    logic signed [SCR_W:0]    d1, d2;
    logic [1:0]               xj;
    logic [1:0]               kk;
    logic signed [31:0]       ld_c;
    logic [31:0]              mag_c;
    logic [31:0]              mag_w;
    logic [PROD_W-1:0]        mag_n;
    logic [PROD_W-1:0]        mag_d;
    logic signed [31:0]       qsat;
    logic signed [PROD_W-1:0] abc;
    logic                     tri_degen;
    logic                     pix_in;
    logic signed [DACC_W-1:0] dshift;
    logic signed [31:0]       dclamp;
    logic                     wr_hit;
    logic                     mem_we;
    logic [DB_AW-1:0]         mem_addr;
    logic [12:0]              idx_full;
    out_t                     res_start;

    function automatic logic signed [SCR_W-1:0] map_coord(
        input logic signed [PROD_W-1:0] p,
        input logic [DIM_W-1:0]         dim
    );
        logic signed [40:0] sum;
        logic signed [40:0] half;
        logic signed [SCR_W-1:0] r;
        sum  = $signed(p[40:0]) + $signed({18'd0, dim - 7'd1, {FRAC_BITS{1'b0}}});
        half = sum >>> 1;
        if (half > MAP_HI)
        begin
            r = MAP_HI[SCR_W-1:0];
        end
        else if (half < MAP_LO)
        begin
            r = MAP_LO[SCR_W-1:0];
        end
        else
        begin
            r = half[SCR_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PROD_W-1:0] mag62(input logic signed [PROD_W-1:0] v);
        return v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    endfunction

    tfdt_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .stat (div_stat)
    );

    assign xj       = step_reg[2:1];
    assign kk       = step_reg[1:0];
    assign clearing = (state_reg == S_CLR);
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign idx_full = 13'(q_item.py * dims.wd) + 13'(q_item.px);

    // Starting result for a newly taken transaction.
    always_comb
    begin
        res_start = '0;
        if (q_item.kind == KIND_TEST)
        begin
            res_start.pixel_index = idx_full[11:0];
        end
        else if (q_item.kind == KIND_LOAD && q_item.wzero)
        begin
            res_start.degenerate = 1'b1;
        end
    end

    // Edge-function operands; the pixel position is taken at integer coordinates.
    always_comb
    begin
        fx = $signed({{(SCR_W-PIX_W-FRAC_BITS){1'b0}}, cmd_reg.px, {FRAC_BITS{1'b0}}});
        fy = $signed({{(SCR_W-PIX_W-FRAC_BITS){1'b0}}, cmd_reg.py, {FRAC_BITS{1'b0}}});
        case (xj)
            2'd0:
            begin
                ax = sx_reg[0]; ay = sy_reg[0];
                bx = sx_reg[1]; by = sy_reg[1];
                cx = sx_reg[2]; cy = sy_reg[2];
            end
            2'd1:
            begin
                ax = fx;        ay = fy;
                bx = sx_reg[1]; by = sy_reg[1];
                cx = sx_reg[2]; cy = sy_reg[2];
            end
            2'd2:
            begin
                ax = fx;        ay = fy;
                bx = sx_reg[2]; by = sy_reg[2];
                cx = sx_reg[0]; cy = sy_reg[0];
            end
            default:
            begin
                ax = fx;        ay = fy;
                bx = sx_reg[0]; by = sy_reg[0];
                cx = sx_reg[1]; cy = sy_reg[1];
            end
        endcase
        if (!step_reg[0])
        begin
            d1 = (SCR_W+1)'(bx) - (SCR_W+1)'(ax);
            d2 = (SCR_W+1)'(cy) - (SCR_W+1)'(ay);
        end
        else
        begin
            d1 = (SCR_W+1)'(cx) - (SCR_W+1)'(ax);
            d2 = (SCR_W+1)'(by) - (SCR_W+1)'(ay);
        end
    end

    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = 33'(qx_reg);
                mul_b = $signed({26'd0, dims.wd});
            end
            S_MY:
            begin
                mul_a = 33'(qy_reg);
                mul_b = $signed({26'd0, dims.ht});
            end
            S_DMUL:
            begin
                mul_a = $signed({16'd0, wt_reg[kk]});
                mul_b = 33'(sz_reg[kk]);
            end
            default:
            begin
                mul_a = 33'(d1);
                mul_b = 33'(d2);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Load-side divide: |c| * 2^FRAC_BITS / |w|, sign applied afterwards.
    always_comb
    begin
        case (kk)
            2'd0:    ld_c = cmd_reg.cx;
            2'd1:    ld_c = cmd_reg.cy;
            default: ld_c = cmd_reg.cz;
        endcase
        mag_c = ld_c[31] ? 32'(-ld_c) : 32'(ld_c);
        mag_w = cmd_reg.cw[31] ? 32'(-cmd_reg.cw) : 32'(cmd_reg.cw);
        abc   = cross_reg[0];
        mag_d = mag62(abc);
        case (kk)
            2'd0:    mag_n = mag62(cross_reg[1]);
            2'd1:    mag_n = mag62(cross_reg[2]);
            default: mag_n = mag62(cross_reg[3]);
        endcase

        div_req = '0;
        if (state_reg == S_LSTART)
        begin
            div_req.start = 1'b1;
            div_req.rem0  = '0;
            div_req.den   = DIV_RW'(mag_w);
            div_req.num   = {mag_c, {FRAC_BITS{1'b0}}};
            div_req.count = DIV_CW'(DIV_NW);
        end
        else if (state_reg == S_WSTART)
        begin
            // A weight can equal one only when the numerator equals the area.
            div_req.start = 1'b1;
            div_req.rem0  = (mag_n >= mag_d) ? '0 : DIV_RW'(mag_n);
            div_req.den   = DIV_RW'(mag_d);
            div_req.num   = '0;
            div_req.count = DIV_CW'(FRAC_BITS);
        end

        if (!neg_reg)
        begin
            qsat = (div_stat.quot > 48'h0000_7FFF_FFFF) ? $signed(DEPTH_MAX)
                                                       : $signed(div_stat.quot[31:0]);
        end
        else
        begin
            qsat = (div_stat.quot > 48'h0000_8000_0000) ? $signed(DEPTH_MIN)
                                                       : $signed(32'(-div_stat.quot[31:0]));
        end

        tri_degen = (abc == '0) || (wz_reg != 3'b000);
        if (!abc[PROD_W-1])
        begin
            pix_in = !cross_reg[1][PROD_W-1] && !cross_reg[2][PROD_W-1]
                     && !cross_reg[3][PROD_W-1];
        end
        else
        begin
            pix_in = (cross_reg[1] <= 0) && (cross_reg[2] <= 0) && (cross_reg[3] <= 0);
        end

        dshift = dacc_reg >>> FRAC_BITS;
        if (dshift > DZ_HI)
        begin
            dclamp = $signed(DEPTH_MAX);
        end
        else if (dshift < DZ_LO)
        begin
            dclamp = $signed(DEPTH_MIN);
        end
        else
        begin
            dclamp = dshift[31:0];
        end

        wr_hit   = in_range_reg && (depth_reg < $signed(rd_data_reg));
        mem_we   = clearing || ((state_reg == S_RD) && wr_hit);
        mem_addr = clearing ? clr_cnt_reg : idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == DB_AW'(DB_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.kind == KIND_TEST)
                    begin
                        state_next = S_XMUL;
                    end
                    else if (q_item.kind == KIND_LOAD && !q_item.wzero)
                    begin
                        state_next = S_LSTART;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_LSTART: state_next = S_LWAIT;
            S_LWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (kk == 2'd2) ? S_MX : S_LSTART;
                end
            end
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_MW;
            S_MW:   state_next = S_OUT;
            S_XMUL: state_next = S_XACC;
            S_XACC: state_next = (step_reg == 3'd7) ? S_TCHK : S_XMUL;
            S_TCHK: state_next = (!tri_degen && pix_in) ? S_WSTART : S_OUT;
            S_WSTART: state_next = S_WWAIT;
            S_WWAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = (kk == 2'd2) ? S_DMUL : S_WSTART;
                end
            end
            S_DMUL: state_next = S_DACC;
            S_DACC: state_next = (kk == 2'd2) ? S_DFIN : S_DMUL;
            S_DFIN: state_next = S_RD;
            S_RD:   state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            depth_mem[mem_addr] <= clearing ? DEPTH_MAX : depth_reg;
        end
        rd_data_reg <= depth_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            wz_reg        <= 3'b111;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sx_reg[i] <= '0;
                sy_reg[i] <= '0;
                sz_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && (!out_valid_reg || !out_stall))
            begin
                out_data_reg  <= res_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg      <= q_item;
                        step_reg     <= '0;
                        idx_reg      <= idx_full[DB_AW-1:0];
                        in_range_reg <= (7'(q_item.px) < dims.wd) && (7'(q_item.py) < dims.ht);
                        res_reg      <= res_start;
                        if (q_item.kind == KIND_LOAD && q_item.wzero)
                        begin
                            sx_reg[q_item.slot] <= '0;
                            sy_reg[q_item.slot] <= '0;
                            sz_reg[q_item.slot] <= '0;
                            wz_reg[q_item.slot] <= 1'b1;
                        end
                    end
                end
                S_LSTART:
                begin
                    neg_reg <= ld_c[31] ^ cmd_reg.cw[31];
                end
                S_LWAIT:
                begin
                    if (div_stat.done)
                    begin
                        case (kk)
                            2'd0:    qx_reg <= qsat;
                            2'd1:    qy_reg <= qsat;
                            default: qz_reg <= qsat;
                        endcase
                        step_reg <= step_reg + 3'd1;
                    end
                end
                S_MX:
                begin
                    prod_reg <= mul_p[PROD_W-1:0];
                end
                S_MY:
                begin
                    mapx_reg <= map_coord(prod_reg, dims.wd);
                    prod_reg <= mul_p[PROD_W-1:0];
                end
                S_MW:
                begin
                    sx_reg[cmd_reg.slot] <= mapx_reg;
                    sy_reg[cmd_reg.slot] <= map_coord(prod_reg, dims.ht);
                    sz_reg[cmd_reg.slot] <= qz_reg;
                    wz_reg[cmd_reg.slot] <= 1'b0;
                end
                S_XMUL:
                begin
                    prod_reg <= mul_p[PROD_W-1:0];
                end
                S_XACC:
                begin
                    if (!step_reg[0])
                    begin
                        acc_reg <= prod_reg;
                    end
                    else
                    begin
                        cross_reg[xj] <= acc_reg - prod_reg;
                    end
                    step_reg <= step_reg + 3'd1;
                end
                S_TCHK:
                begin
                    step_reg <= '0;
                    if (tri_degen)
                    begin
                        res_reg.degenerate <= 1'b1;
                    end
                end
                S_WSTART:
                begin
                    top_reg <= (mag_n >= mag_d);
                end
                S_WWAIT:
                begin
                    if (div_stat.done)
                    begin
                        wt_reg[kk] <= {top_reg, div_stat.quot[FRAC_BITS-1:0]};
                        step_reg   <= (kk == 2'd2) ? 3'd0 : step_reg + 3'd1;
                        dacc_reg   <= '0;
                    end
                end
                S_DMUL:
                begin
                    prod_reg <= mul_p[PROD_W-1:0];
                end
                S_DACC:
                begin
                    dacc_reg <= dacc_reg + prod_reg[DACC_W-1:0];
                    step_reg <= step_reg + 3'd1;
                end
                S_DFIN:
                begin
                    depth_reg <= dclamp;
                end
                S_RD:
                begin
                    res_reg <= {wr_hit, 1'b1, res_reg.degenerate, res_reg.pixel_index,
                                depth_reg, wt_reg[0], wt_reg[1], wt_reg[2]};
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sim/triangle_fragment_depth_test_test.sv =====
// ============================================================================
// triangle_fragment_depth_test_test
// Self-checking testbench for the triangle coverage and z-buffer unit.
// ============================================================================
// Vertex loads and pixel tests are driven on the input channel, and every
// transaction is run through a fixed-point model of the unit. The model keeps
// the vertex slots and the depth buffer. Each result transaction is compared
// field by field with the oldest prediction. Both channels idle at random,
// and the receiver also holds off for a long stretch so that the input backs
// up. The image size registers are swept between phases, extremes included.
// ============================================================================
module triangle_fragment_depth_test_test;
    import tfdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ONE_FX    = 1 << FRAC_BITS;
    localparam longint SCR_LIM   = 64'sd1 << 29;
    localparam longint DMAX      = 64'sd2147483647;
    localparam longint DMIN      = -64'sd2147483648;
    localparam int     WATCHDOG  = 30000;
    localparam int     SETTLE    = 250;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;
    logic             cfg_we;
    logic             cfg_index;
    logic [DIM_W-1:0] cfg_data;

    triangle_fragment_depth_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state.
    logic [DIM_W-1:0] img_w_reg;
    logic [DIM_W-1:0] img_h_reg;
    longint           scr_x [3];
    longint           scr_y [3];
    longint           scr_z [3];
    bit               slot_empty [3];
    longint           zbuf [DB_DEPTH];

    out_t   pending_results [$];
    int     mismatch_count;
    int     items_sent;
    int     results_seen;
    int     writes_seen;
    int     covered_seen;
    int     degenerate_seen;
    bit     in_idle_on;
    bit     out_idle_on;
    int     hold_epoch;
    int     hold_len;
    int     hold_epoch_seen;
    int     hold_left;
    int     burst_left;
    bit     burst_stall;
    int     quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point model
    // ------------------------------------------------------------------------
    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint active_dim(logic [DIM_W-1:0] v, int maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic longint divide_by_w(longint c, longint w);
        return clamp64((c * ONE_FX) / w, DMIN, DMAX);
    endfunction

    function automatic longint edge_area(longint ax, longint ay, longint bx, longint by,
                                         longint cx, longint cy);
        return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // floor(n * 2^FRAC_BITS / d) for 0 <= n <= d, done bit by bit to stay in 64 bits.
    function automatic logic [WT_W-1:0] weight_ratio(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = n / d;
        r = n % d;
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q[WT_W-1:0];
    endfunction

    function automatic void model_reset();
        img_w_reg = 7'd64;
        img_h_reg = 7'd64;
        for (int i = 0; i < 3; i++)
        begin
            scr_x[i] = 0;
            scr_y[i] = 0;
            scr_z[i] = 0;
            slot_empty[i] = 1'b1;
        end
        for (int i = 0; i < DB_DEPTH; i++)
            zbuf[i] = DMAX;
    endfunction

    function automatic out_t predict_fragment(in_t it);
        out_t   r;
        longint wd;
        longint ht;
        longint w;
        longint qx;
        longint qy;
        longint px;
        longint py;
        longint fx;
        longint fy;
        longint idx;
        longint abc;
        longint ca;
        longint cb;
        longint cg;
        longint depth;
        logic [63:0] d;
        bit     covered;
        int     s;
        r = '0;
        wd = active_dim(img_w_reg, MAX_WIDTH);
        ht = active_dim(img_h_reg, MAX_HEIGHT);
        if (it.func == FUNC_LOAD)
        begin
            if (it.vertex_slot == 2'd3)
                return r;
            s = it.vertex_slot;
            w = longint'($signed(it.clip_w));
            if (w == 0)
            begin
                scr_x[s] = 0;
                scr_y[s] = 0;
                scr_z[s] = 0;
                slot_empty[s] = 1'b1;
                r.degenerate = 1'b1;
                return r;
            end
            qx = divide_by_w(longint'($signed(it.clip_x)), w);
            qy = divide_by_w(longint'($signed(it.clip_y)), w);
            // The viewport halving rounds toward minus infinity.
            scr_x[s] = clamp64((qx * wd + (wd - 1) * ONE_FX) >>> 1, -SCR_LIM, SCR_LIM - 1);
            scr_y[s] = clamp64((qy * ht + (ht - 1) * ONE_FX) >>> 1, -SCR_LIM, SCR_LIM - 1);
            scr_z[s] = divide_by_w(longint'($signed(it.clip_z)), w);
            slot_empty[s] = 1'b0;
            return r;
        end
        px = it.pixel_x;
        py = it.pixel_y;
        fx = px * ONE_FX;
        fy = py * ONE_FX;
        idx = py * wd + px;
        r.pixel_index = idx[11:0];
        abc = edge_area(scr_x[0], scr_y[0], scr_x[1], scr_y[1], scr_x[2], scr_y[2]);
        if (abc == 0 || slot_empty[0] || slot_empty[1] || slot_empty[2])
        begin
            r.degenerate = 1'b1;
            return r;
        end
        ca = edge_area(fx, fy, scr_x[1], scr_y[1], scr_x[2], scr_y[2]);
        cb = edge_area(fx, fy, scr_x[2], scr_y[2], scr_x[0], scr_y[0]);
        cg = edge_area(fx, fy, scr_x[0], scr_y[0], scr_x[1], scr_y[1]);
        if (abc > 0)
            covered = (ca >= 0) && (cb >= 0) && (cg >= 0);
        else
            covered = (ca <= 0) && (cb <= 0) && (cg <= 0);
        if (!covered)
            return r;
        d = magnitude(abc);
        r.alpha = weight_ratio(magnitude(ca), d);
        r.beta  = weight_ratio(magnitude(cb), d);
        r.gamma = weight_ratio(magnitude(cg), d);
        depth = longint'(r.alpha) * scr_z[0] + longint'(r.beta) * scr_z[1]
              + longint'(r.gamma) * scr_z[2];
        depth = clamp64(depth >>> FRAC_BITS, DMIN, DMAX);
        r.inside_res = 1'b1;
        r.frag_depth = depth[31:0];
        if (px < wd && py < ht && idx < DB_DEPTH && depth < zbuf[idx])
        begin
            zbuf[idx] = depth;
            r.written = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.written !== want.written)
                    report_mismatch("written", out_data.written, want.written);
                if (out_data.inside_res !== want.inside_res)
                    report_mismatch("inside_res", out_data.inside_res, want.inside_res);
                if (out_data.degenerate !== want.degenerate)
                    report_mismatch("degenerate", out_data.degenerate, want.degenerate);
                if (out_data.pixel_index !== want.pixel_index)
                    report_mismatch("pixel_index", out_data.pixel_index, want.pixel_index);
                if (out_data.frag_depth !== want.frag_depth)
                    report_mismatch("frag_depth", out_data.frag_depth, want.frag_depth);
                if (out_data.alpha !== want.alpha)
                    report_mismatch("alpha", out_data.alpha, want.alpha);
                if (out_data.beta !== want.beta)
                    report_mismatch("beta", out_data.beta, want.beta);
                if (out_data.gamma !== want.gamma)
                    report_mismatch("gamma", out_data.gamma, want.gamma);
                writes_seen += want.written;
                covered_seen += want.inside_res;
                degenerate_seen += want.degenerate;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stalls: random bursts, plus a long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_epoch_seen <= 0;
            burst_left <= 0;
            burst_stall <= 1'b0;
        end
        else if (hold_epoch != hold_epoch_seen)
        begin
            hold_epoch_seen <= hold_epoch;
            hold_left <= hold_len;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end
        else if (!out_idle_on)
            out_stall <= 1'b0;
        else if (burst_left > 0)
        begin
            burst_left <= burst_left - 1;
            out_stall <= burst_stall;
        end
        else
        begin
            burst_stall <= ($urandom_range(0, 9) < 4);
            if ($urandom_range(0, 9) == 0)
                burst_left <= $urandom_range(20, 60);
            else
                burst_left <= $urandom_range(1, 4);
            out_stall <= 1'b0;
        end
    end

    // Ends the run if nothing moves for too long while work is outstanding.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (!in_valid && pending_results.size() == 0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog expired after %0d cycles without progress", WATCHDOG);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int p;
        if (!in_idle_on)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.push_back(predict_fragment(it));
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= h;
        img_w_reg = w;
        @(posedge clk);
        cfg_we <= 1'b0;
        img_h_reg = h;
    endtask

    function automatic in_t load_item(logic [1:0] slot, int x, int y, int z, int w);
        in_t it;
        it = '0;
        it.func = FUNC_LOAD;
        it.vertex_slot = slot;
        it.clip_x = x;
        it.clip_y = y;
        it.clip_z = z;
        it.clip_w = w;
        it.pixel_x = PIX_W'($urandom());
        it.pixel_y = PIX_W'($urandom());
        return it;
    endfunction

    function automatic in_t test_item(int x, int y);
        in_t it;
        it = '0;
        it.func = FUNC_TEST;
        it.vertex_slot = 2'($urandom());
        it.clip_x = $urandom();
        it.clip_y = $urandom();
        it.clip_z = $urandom();
        it.clip_w = $urandom();
        it.pixel_x = PIX_W'(x);
        it.pixel_y = PIX_W'(y);
        return it;
    endfunction

    function automatic int unit_coord();
        return int'($urandom_range(0, 2 * 80000)) - 80000;
    endfunction

    // A vertex that usually lands on screen; now and then an odd w.
    function automatic in_t random_vertex(logic [1:0] slot);
        int w;
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            w = ONE_FX;
        else if (p < 90)
            w = $urandom_range(20000, 200000);
        else if (p < 96)
            w = -int'($urandom_range(20000, 200000));
        else
            w = 0;
        return load_item(slot, unit_coord(), unit_coord(), $urandom(), w);
    endfunction

    function automatic in_t noise_item();
        in_t          it;
        logic [159:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        it = raw[$bits(in_t)-1:0];
        if ($urandom_range(0, 1))
            it.clip_w = ONE_FX;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_item(test_item(5, 5));
        send_item(load_item(2'd3, ONE_FX, ONE_FX, ONE_FX, ONE_FX));
        send_item(load_item(2'd0, 1, 2, 3, 0));
        send_item(load_item(2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
        send_item(load_item(2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -1));
        send_item(load_item(2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000));
        send_item(test_item(63, 63));
        // Zero-area triangle: all three vertices on one point.
        for (int s = 0; s < 3; s++)
            send_item(load_item(2'(s), 0, 0, ONE_FX / 2, ONE_FX));
        send_item(test_item(31, 31));
        send_item(load_item(2'd0, -ONE_FX, -ONE_FX, ONE_FX / 2, ONE_FX));
        send_item(load_item(2'd1, ONE_FX, -ONE_FX, -ONE_FX / 4, ONE_FX));
        send_item(load_item(2'd2, -ONE_FX, ONE_FX, ONE_FX / 8, ONE_FX));
        send_item(test_item(0, 0));
        send_item(test_item(10, 20));
        send_item(test_item(10, 20));
        send_item(test_item(63, 63));
        send_item(test_item(63, 0));
        send_item(test_item(0, 63));
        send_item(test_item(32, 31));
        // Reversed winding.
        send_item(load_item(2'd1, -ONE_FX, ONE_FX, 0, ONE_FX));
        send_item(load_item(2'd2, ONE_FX, -ONE_FX, -ONE_FX, ONE_FX));
        send_item(test_item(5, 7));
        send_item(test_item(62, 62));
    endtask

    task automatic run_random(int count);
        int n;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                for (int s = 0; s < 3; s++)
                begin
                    send_item(random_vertex(2'(s)));
                    n++;
                end
                repeat ($urandom_range(4, 14))
                begin
                    send_item(test_item($urandom_range(0, 63), $urandom_range(0, 63)));
                    n++;
                end
            end
            else
            begin
                send_item(noise_item());
                n++;
            end
        end
    endtask

    task automatic test_dimension_extremes();
        write_dims(7'd0, 7'd0);
        run_random(40);
        write_dims(7'd1, 7'd64);
        run_random(40);
        write_dims(7'd127, 7'd1);
        run_random(40);
        write_dims(7'd64, 7'd127);
        run_random(40);
        write_dims(7'd8, 7'd8);
        run_random(40);
    endtask

    task automatic test_random_traffic();
        write_dims(7'd64, 7'd64);
        run_random(700);
        write_dims(7'($urandom_range(2, 63)), 7'($urandom_range(2, 63)));
        in_idle_on = 1'b0;
        out_idle_on = 1'b0;
        run_random(150);
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        run_random(300);
        write_dims(7'd64, 7'd64);
        run_random(500);
    endtask

    task automatic test_backpressure();
        wait_idle();
        in_idle_on = 1'b0;
        hold_len = 600;
        hold_epoch++;
        for (int s = 0; s < 3; s++)
            send_item(load_item(2'(s), unit_coord(), unit_coord(), $urandom(), ONE_FX));
        repeat (12)
            send_item(test_item($urandom_range(0, 63), $urandom_range(0, 63)));
        in_idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= '0;
        mismatch_count = 0;
        items_sent = 0;
        results_seen = 0;
        writes_seen = 0;
        covered_seen = 0;
        degenerate_seen = 0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        hold_epoch = 0;
        hold_len = 0;
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_dimension_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        $display("%0d transactions sent, %0d results checked: %0d covered, %0d depth writes,",
                 items_sent, results_seen, covered_seen, writes_seen);
        $display("%0d degenerate; image sizes swept from 0 to 127 with long receiver hold-off.",
                 degenerate_seen);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
